[rtl/assert_macros.svh]
// Assertion macros shared by the range-sum counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RSSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define RSSC_ASSERT_NEVER(lbl, cond, msg) \
  `RSSC_ASSERT(lbl, !(cond), msg)

`endif

[rtl/rssc_pkg.sv]
// Package: sizes, controller state and command/status types of the range-sum counter.
`timescale 1ns / 1ps
package rssc_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int VAL_W     = 32;
  localparam int AW        = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 2);
  localparam int HIT_W     = $clog2(MAX_ITEMS + 1);
  localparam int PSUM_W    = VAL_W + $clog2(MAX_ITEMS);
  localparam int CMP_W     = PSUM_W + 1;
  localparam int EH_W      = 11;
  localparam int TOT_W     = 20;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load;
  } rssc_cmd_t;

  typedef struct packed {
    logic skip;
    logic scan_last;
    logic out_free;
  } rssc_sts_t;

endpackage

[rtl/rssc_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module rssc_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rssc_ctrl.sv]
// Controller: sequences accept, store scan, drain and result load.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rssc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rssc_pkg::rssc_sts_t st,
  output rssc_pkg::rssc_cmd_t cmd
);
  import rssc_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = st.skip ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `RSSC_ASSERT(a_done_to_idle, (state_r == S_DONE && st.out_free) |=> (state_r == S_IDLE), "result load did not return to idle")

endmodule

[rtl/rssc_dp.sv]
// Datapath: prefix sum, store scan with one comparator pair, counters and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rssc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rssc_pkg::rssc_cmd_t                cmd,
  output rssc_pkg::rssc_sts_t                st,
  input  logic signed [rssc_pkg::VAL_W-1:0]  lower,
  input  logic signed [rssc_pkg::VAL_W-1:0]  upper,
  input  logic signed [rssc_pkg::VAL_W-1:0]  in_value,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rssc_pkg::EH_W-1:0]          out_ending_here,
  output logic [rssc_pkg::TOT_W-1:0]         out_running_total,
  output logic                               out_overflow,
  output logic                               out_done_res
);
  import rssc_pkg::*;

  logic signed [PSUM_W-1:0] psum_r;
  logic signed [CMP_W-1:0]  lo_r, hi_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [TOT_W-1:0]         tot_r;
  logic                     ovf_r;
  logic [HIT_W-1:0]         hits_r;
  logic [AW-1:0]            scan_addr_r;
  logic                     rd_vld_r;
  logic                     rd_zero_r;
  logic                     skip_r;
  logic                     last_r;
  logic                     out_valid_r;
  logic [EH_W-1:0]          out_eh_r;
  logic [TOT_W-1:0]         out_tot_r;
  logic                     out_ovf_r;
  logic                     out_done_r;

  logic signed [PSUM_W-1:0] psum_nxt;
  logic signed [PSUM_W-1:0] ram_rdata;
  logic signed [CMP_W-1:0]  p_ext;
  logic                     hit;
  logic [TOT_W-1:0]         tot_nxt;
  logic                     ram_we;

  assign psum_nxt = psum_r + PSUM_W'(in_value);
  assign p_ext    = rd_zero_r ? '0 : CMP_W'(ram_rdata);
  assign hit      = (p_ext >= lo_r) && (p_ext <= hi_r);
  assign tot_nxt  = tot_r + TOT_W'(hits_r);
  assign ram_we   = cmd.load && !skip_r && (cnt_r < CNT_W'(MAX_ITEMS));

  assign st.skip      = cnt_r > CNT_W'(MAX_ITEMS);
  assign st.scan_last = CNT_W'(scan_addr_r) == (cnt_r - CNT_W'(1));
  assign st.out_free  = !out_valid_r || !out_stall;

  rssc_ram #(
    .W     (PSUM_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (psum_r),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  // window bounds are registered from psum_r in the cycle after it changes, ahead of the first compare
  always_ff @(posedge clk) begin
    lo_r      <= CMP_W'(psum_r) - CMP_W'(upper);
    hi_r      <= CMP_W'(psum_r) - CMP_W'(lower);
    rd_zero_r <= (scan_addr_r == '0);
    if (cmd.accept) begin
      last_r <= in_last;
    end
    if (cmd.load) begin
      out_eh_r   <= EH_W'(hits_r);
      out_tot_r  <= tot_nxt;
      out_ovf_r  <= ovf_r;
      out_done_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psum_r      <= '0;
      cnt_r       <= CNT_W'(1);
      tot_r       <= '0;
      ovf_r       <= 1'b0;
      hits_r      <= '0;
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.accept) begin
        skip_r      <= st.skip;
        scan_addr_r <= '0;
        hits_r      <= '0;
        if (st.skip) begin
          ovf_r <= 1'b1;
        end else begin
          psum_r <= psum_nxt;
        end
      end
      if (cmd.scan) begin
        scan_addr_r <= scan_addr_r + AW'(1);
      end
      if (rd_vld_r && hit) begin
        hits_r <= hits_r + HIT_W'(1);
      end
      if (cmd.load) begin
        if (last_r) begin
          psum_r <= '0;
          cnt_r  <= CNT_W'(1);
          tot_r  <= '0;
          ovf_r  <= 1'b0;
        end else begin
          tot_r <= tot_nxt;
          if (!skip_r) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ending_here   = out_eh_r;
  assign out_running_total = out_tot_r;
  assign out_overflow      = out_ovf_r;
  assign out_done_res      = out_done_r;

  `RSSC_ASSERT(a_cnt_range, (cnt_r >= CNT_W'(1)) && (cnt_r <= CNT_W'(MAX_ITEMS + 1)), "stored count out of range")
  `RSSC_ASSERT_NEVER(a_no_wr_in_scan, ram_we && cmd.scan, "store written during scan")
  `RSSC_ASSERT_NEVER(a_drained, cmd.load && rd_vld_r, "result loaded before compare drained")

endmodule

[rtl/range_sum_subarray_counter.sv]
// Top level: configuration registers, controller and datapath of the range-sum counter.
//
// Usage:
// - Input beats (in_value, in_last) carry one array element each; in_last marks the end.
// - Each input beat yields one output beat: ending_here, running_total, overflow, done_res.
// - Write lower (0x0), upper (0x4) bound registers over APB only while idle; unenforced.
// - An element is compared against every prefix sum held for the current array by one
//   comparator pair walking the prefix store, one entry per cycle.
// - With k prefixes held (1 to MAX_ITEMS), an item scans the k entries in S_SCAN, then
//   passes S_DRAIN and S_DONE, which loads its output beat and returns to S_IDLE.
// - An element past MAX_ITEMS is not scanned; it goes from S_IDLE straight to S_DONE.
// - One item is in work at a time; the output register lets the next item be accepted
//   while a result still waits.
// - A stalled output holds its beat; a new result waits until the output is free.
// - Reset clears the counters and bounds; the store needs no clearing pass.
// - After the beat for a last element the per-array state returns to reset values.
`timescale 1ns / 1ps
module range_sum_subarray_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [rssc_pkg::VAL_W-1:0] in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rssc_pkg::EH_W-1:0]         out_ending_here,
  output logic [rssc_pkg::TOT_W-1:0]        out_running_total,
  output logic                              out_overflow,
  output logic                              out_done_res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import rssc_pkg::*;

  localparam logic REG_LOWER = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  logic signed [VAL_W-1:0] lower_r, upper_r;
  rssc_cmd_t               cmd;
  rssc_sts_t               st;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_LOWER: lower_r <= pwdata;
        REG_UPPER: upper_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LOWER: prdata = lower_r;
      REG_UPPER: prdata = upper_r;
      default:   prdata = '0;
    endcase
  end

  rssc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  rssc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .lower             (lower_r),
    .upper             (upper_r),
    .in_value          (in_value),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ending_here   (out_ending_here),
    .out_running_total (out_running_total),
    .out_overflow      (out_overflow),
    .out_done_res      (out_done_res)
  );

endmodule
